[rtl/core/u8pwd_pkg.sv]
// ----------------------------------------------------------------------------
// u8pwd_pkg
// shared types and constants of the pulse-width uart 8n1 decoder
// ----------------------------------------------------------------------------
`default_nettype none

package u8pwd_pkg;

  // width of one decoded byte and of the bit time register
  localparam int unsigned ByteW    = 8;
  localparam int unsigned TicksW   = 8;
  localparam int unsigned CountW   = 4;

  // bit count saturation point
  localparam logic [CountW-1:0] CountSat = 4'd9;

  // bit time after reset
  localparam logic [TicksW-1:0] BitTicksRst = 8'd52;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_PADDED  = 2'd1,
    ST_INVALID = 2'd2,
    ST_NO_STOP = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_LOW,
    S_HIGH,
    S_FIN,
    S_EMIT
  } state_e;

endpackage

`default_nettype wire

[rtl/core/uart_8n1_pulse_width_decoder_core.sv]
// ----------------------------------------------------------------------------
// uart_8n1_pulse_width_decoder_core
// rebuilds 8n1 uart bytes, lsb first, from captured low/high pulse durations
// ----------------------------------------------------------------------------
// usage
//   input channel: one word per captured symbol (first part level and
//   duration, second high part duration, last-of-burst flag), valid/stall.
//   output channel: zero or one word per symbol (rx_byte, status),
//   valid/stall, held in an output register.
//   config channel: valid/ready write of the bit time, always ready; write it
//   only while the decoder is idle.
//   throughput: one shared compare/subtract unit peels one bit
//   time per cycle. a symbol passes the start, low part, high part and
//   finish steps, skips the high part when it ends in the low part, goes
//   from start straight to finish when no frame is open and it holds no
//   start bit, and takes an emit step when it makes a word.
//   in_stall_o is high while a symbol is being worked on.
//   reset: frame state clears, the bit time returns to 52, no word pending.
//   output stall: a finished word waits in the output register; the next
//   symbol is still accepted, and only a second word waits for the register.
// ----------------------------------------------------------------------------
`default_nettype none

module uart_8n1_pulse_width_decoder_core
  import u8pwd_pkg::*;
#(
  parameter int unsigned CHAR_BITS     = 8,
  parameter int unsigned DURATION_BITS = 15
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // configuration write
  input  wire logic                     cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire logic [TicksW-1:0]        cfg_data_i,
  // symbol input
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic                     first_level_i,
  input  wire logic [DURATION_BITS-1:0] first_duration_i,
  input  wire logic                     second_level_i,
  input  wire logic [DURATION_BITS-1:0] second_duration_i,
  input  wire logic                     last_of_burst_i,
  // decoded output
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic [ByteW-1:0]              rx_byte_o,
  output logic [1:0]                    status_o
);

  localparam logic [CountW-1:0] CharBitsC = CountW'(CHAR_BITS);

  state_e                   state_q, state_d;
  logic [TicksW-1:0]        bit_time_q, bit_time_d;
  logic                     frame_open_q, frame_open_d;
  logic [CountW-1:0]        bits_q, bits_d;
  logic [ByteW-1:0]         acc_q, acc_d;
  // duration under work: first part, then second part
  logic [DURATION_BITS-1:0] dur_q, dur_d;
  logic [DURATION_BITS-1:0] d1_q, d1_d;
  logic                     lvl_q, lvl_d;
  logic                     last_q, last_d;
  // pending result of the current symbol
  logic                     res_q, res_d;
  logic [ByteW-1:0]         res_byte_q, res_byte_d;
  status_e                  res_status_q, res_status_d;
  // output register
  logic                     out_valid_q, out_valid_d;
  logic [ByteW-1:0]         out_byte_q, out_byte_d;
  status_e                  out_status_q, out_status_d;

  logic                     in_accept;
  logic [TicksW-1:0]        thr;
  logic                     dur_gt;
  logic [DURATION_BITS-1:0] dur_take;
  logic [ByteW-1:0]         bit_set;
  logic [ByteW-1:0]         pad_mask;

  assign in_accept = in_valid_i && !in_stall_o;

  // shared unit: threshold compare and one bit time subtraction
  assign thr      = bit_time_q - {2'b00, bit_time_q[TicksW-1:2]};
  assign dur_gt   = dur_q > DURATION_BITS'(thr);
  assign dur_take = (dur_q >= DURATION_BITS'(bit_time_q))
                    ? dur_q - DURATION_BITS'(bit_time_q) : '0;

  // one bit at the current bit position, none past bit 7
  assign bit_set = (bits_q < CountW'(ByteW)) ? (ByteW'(1) << bits_q) : '0;

  // ones from the current bit position up to the last data bit
  always_comb begin
    for (int i = 0; i < ByteW; i++) begin
      pad_mask[i] = (CountW'(i) >= bits_q) && (CountW'(i) < CharBitsC);
    end
  end

  always_comb begin
    state_d      = state_q;
    bit_time_d   = bit_time_q;
    frame_open_d = frame_open_q;
    bits_d       = bits_q;
    acc_d        = acc_q;
    dur_d        = dur_q;
    d1_d         = d1_q;
    lvl_d        = lvl_q;
    last_d       = last_q;
    res_d        = res_q;
    res_byte_d   = res_byte_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_byte_d   = out_byte_q;
    out_status_d = out_status_q;

    if (cfg_valid_i) begin
      bit_time_d = cfg_data_i;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          // second_level_i carries no information for the decoder
          dur_d   = first_duration_i;
          d1_d    = second_duration_i;
          lvl_d   = first_level_i;
          last_d  = last_of_burst_i;
          res_d   = 1'b0;
          state_d = S_START;
        end
      end
      S_START: begin
        if (frame_open_q) begin
          if (lvl_q) begin
            // high first part inside a frame
            frame_open_d = 1'b0;
            res_d        = 1'b1;
            res_byte_d   = '0;
            res_status_d = ST_INVALID;
            state_d      = S_FIN;
          end else begin
            state_d = S_LOW;
          end
        end else if (!lvl_q && dur_gt) begin
          // start bit eats one bit time
          frame_open_d = 1'b1;
          bits_d       = '0;
          acc_d        = '0;
          dur_d        = dur_take;
          state_d      = S_LOW;
        end else begin
          state_d = S_FIN;
        end
      end
      S_LOW: begin
        if (dur_gt && (bits_q < CountSat)) begin
          bits_d = bits_q + 1'b1;
          dur_d  = dur_take;
        end else if (bits_q > CharBitsC) begin
          frame_open_d = 1'b0;
          res_d        = 1'b1;
          res_byte_d   = '0;
          res_status_d = ST_NO_STOP;
          state_d      = S_FIN;
        end else begin
          dur_d   = d1_q;
          state_d = S_HIGH;
        end
      end
      S_HIGH: begin
        if (dur_gt) begin
          if (bits_q >= CharBitsC) begin
            // stop bit
            frame_open_d = 1'b0;
            res_d        = 1'b1;
            res_byte_d   = acc_q;
            res_status_d = ST_DONE;
            state_d      = S_FIN;
          end else begin
            acc_d  = acc_q | bit_set;
            bits_d = bits_q + 1'b1;
            dur_d  = dur_take;
          end
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        state_d = res_q ? S_EMIT : S_IDLE;
        if (last_q) begin
          if (frame_open_q && !res_q) begin
            res_d        = 1'b1;
            res_byte_d   = acc_q | pad_mask;
            res_status_d = ST_PADDED;
            state_d      = S_EMIT;
          end
          frame_open_d = 1'b0;
          bits_d       = '0;
          acc_d        = '0;
        end
      end
      S_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_byte_d   = res_byte_q;
          out_status_d = res_status_q;
          res_d        = 1'b0;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      bit_time_q   <= BitTicksRst;
      frame_open_q <= 1'b0;
      bits_q       <= '0;
      acc_q        <= '0;
      res_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      bit_time_q   <= bit_time_d;
      frame_open_q <= frame_open_d;
      bits_q       <= bits_d;
      acc_q        <= acc_d;
      res_q        <= res_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    dur_q        <= dur_d;
    d1_q         <= d1_d;
    lvl_q        <= lvl_d;
    last_q       <= last_d;
    res_byte_q   <= res_byte_d;
    res_status_q <= res_status_d;
    out_byte_q   <= out_byte_d;
    out_status_q <= out_status_d;
  end

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign rx_byte_o   = out_byte_q;
  assign status_o    = out_status_q;

  // bit count never passes saturation
  a_bits_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bits_q <= CountSat)
    else $error("bit count above saturation");

  // burst end leaves no open frame
  a_burst_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && last_q) |=> (!frame_open_q && bits_q == '0))
    else $error("frame state not cleared at burst end");

  // error words carry a zero byte
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_INVALID || status_o == ST_NO_STOP))
      |-> (rx_byte_o == '0))
    else $error("error word with nonzero byte");

  // an accepted word always starts the sequencer
  a_accept_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == S_START))
    else $error("accepted word did not start decoding");

endmodule

`default_nettype wire
